FILE: rtl/core/itda_pkg.sv
// Shared constants and controller/datapath interface types for the
// integer-to-decimal-ASCII block. No dependencies.
`timescale 1ns / 1ps

package itda_pkg;

  localparam int VALUE_W      = 32;  // input integer width
  localparam int CHAR_W       = 7;   // ASCII code width
  localparam int TDATA_OUT_W  = 8;   // character padded to a whole byte
  localparam int DIGITS       = 10;  // decimal digits of a 32-bit magnitude
  localparam int DIGIT_W      = 4;   // BCD digit width
  localparam int BCD_W        = DIGITS * DIGIT_W;
  localparam int IDX_W        = $clog2(DIGITS);
  localparam int BITS_PER_STEP = 4;  // double-dabble bits per cycle
  localparam int STEPS        = VALUE_W / BITS_PER_STEP;
  localparam int STEP_CNT_W   = $clog2(STEPS);

  localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 7'd48;
  localparam logic [CHAR_W-1:0]  ASCII_MINUS = 7'd45;
  localparam logic [DIGIT_W-1:0] BCD_ADJ_MIN = 4'd5;
  localparam logic [DIGIT_W-1:0] BCD_ADJ     = 4'd3;

  // Controller -> datapath commands
  typedef struct packed {
    logic             load;      // capture a new value, clear BCD
    logic             shift;     // run one conversion step
    logic             out_load;  // load the output character register
    logic             out_sign;  // output character is the minus sign
    logic             out_last;  // output character ends the text
    logic [IDX_W-1:0] out_idx;   // digit to send when not the sign
  } itda_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic             neg;       // value was negative
    logic [IDX_W-1:0] msd;       // index of most significant nonzero digit
  } itda_status_t;

endpackage

FILE: rtl/core/itda_datapath.sv
// Datapath: magnitude/BCD shift registers (double dabble, four bits per
// step) and the output character register. Uses itda_pkg.
`timescale 1ns / 1ps

module itda_datapath (
  input  logic                                clk,
  input  logic [itda_pkg::VALUE_W-1:0]        value,
  input  itda_pkg::itda_cmd_t                 cmd,
  output itda_pkg::itda_status_t              status,
  output logic [itda_pkg::CHAR_W-1:0]         character,
  output logic                                last
);

  logic [itda_pkg::VALUE_W-1:0] mag;
  logic [itda_pkg::BCD_W-1:0]   bcd;
  logic                         neg;
  logic [itda_pkg::VALUE_W-1:0] mag_next;
  logic [itda_pkg::BCD_W-1:0]   bcd_next;
  logic [itda_pkg::DIGIT_W-1:0] dig [itda_pkg::DIGITS];
  logic [itda_pkg::IDX_W-1:0]   msd;

  // Four dependent add-3/shift iterations per cycle
  always_comb begin
    logic [itda_pkg::BCD_W-1:0]   b;
    logic [itda_pkg::VALUE_W-1:0] m;
    b = bcd;
    m = mag;
    for (int it = 0; it < itda_pkg::BITS_PER_STEP; it++) begin
      for (int d = 0; d < itda_pkg::DIGITS; d++) begin
        if (b[d*itda_pkg::DIGIT_W +: itda_pkg::DIGIT_W] >= itda_pkg::BCD_ADJ_MIN) begin
          b[d*itda_pkg::DIGIT_W +: itda_pkg::DIGIT_W] =
            b[d*itda_pkg::DIGIT_W +: itda_pkg::DIGIT_W] + itda_pkg::BCD_ADJ;
        end
      end
      b = {b[itda_pkg::BCD_W-2:0], m[itda_pkg::VALUE_W-1]};
      m = {m[itda_pkg::VALUE_W-2:0], 1'b0};
    end
    bcd_next = b;
    mag_next = m;
  end

  always_comb begin
    for (int d = 0; d < itda_pkg::DIGITS; d++) begin
      dig[d] = bcd[d*itda_pkg::DIGIT_W +: itda_pkg::DIGIT_W];
    end
  end

  // Highest nonzero digit; zero maps to digit 0
  always_comb begin
    msd = '0;
    for (int d = 0; d < itda_pkg::DIGITS; d++) begin
      if (dig[d] != '0) begin
        msd = itda_pkg::IDX_W'(d);
      end
    end
  end

  assign status.neg = neg;
  assign status.msd = msd;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg <= value[itda_pkg::VALUE_W-1];
      // unsigned negate: the most negative value maps to 2^31
      mag <= value[itda_pkg::VALUE_W-1] ? (~value + 1'b1) : value;
      bcd <= '0;
    end else if (cmd.shift) begin
      mag <= mag_next;
      bcd <= bcd_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      character <= cmd.out_sign ? itda_pkg::ASCII_MINUS
                                : itda_pkg::ASCII_ZERO + itda_pkg::CHAR_W'(dig[cmd.out_idx]);
      last      <= cmd.out_last;
    end
  end

endmodule

FILE: rtl/core/itda_ctrl.sv
// Controller state machine: sequences capture, conversion steps and
// character output, and owns the output valid flag. Uses itda_pkg.
`timescale 1ns / 1ps

module itda_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  itda_pkg::itda_status_t status,
  output itda_pkg::itda_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SETUP,
    ST_EMIT
  } state_t;

  state_t                          state;
  logic [itda_pkg::STEP_CNT_W-1:0] cnt;
  logic [itda_pkg::IDX_W-1:0]      idx;
  logic                            sign_pend;
  logic                            slot_free;

  assign in_ready  = (state == ST_IDLE);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    cmd          = '0;
    cmd.load     = in_valid && in_ready;
    cmd.shift    = (state == ST_CONV);
    cmd.out_idx  = idx;
    cmd.out_sign = sign_pend;
    cmd.out_last = !sign_pend && (idx == '0);
    cmd.out_load = (state == ST_EMIT) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      idx       <= '0;
      sign_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // drop valid on a taken character unless a new one replaces it
      if (out_valid && out_ready && !cmd.out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            cnt   <= '0;
            state <= ST_CONV;
          end
        end
        ST_CONV: begin
          cnt <= cnt + 1'b1;
          if (cnt == itda_pkg::STEP_CNT_W'(itda_pkg::STEPS - 1)) begin
            state <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          idx       <= status.msd;
          sign_pend <= status.neg;
          state     <= ST_EMIT;
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            if (sign_pend) begin
              sign_pend <= 1'b0;
            end else if (idx == '0) begin
              state <= ST_IDLE;
            end else begin
              idx <= idx - 1'b1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/int_to_decimal_ascii.sv
// Top level of the signed 32-bit integer to decimal ASCII converter.
// Instantiates itda_ctrl and itda_datapath; uses itda_pkg.
`timescale 1ns / 1ps

// Each input item is one two's complement 32-bit integer; the block sends
// its decimal text as ASCII, one character per output item: a '-' first for
// negative values, then the digits most significant first with no leading
// zeros ("0" for zero, "-2147483648" for the most negative value). The final
// character of a number carries tlast; no terminator follows. Timing: an item
// is taken in the idle cycle, the magnitude is converted to BCD by a double-
// dabble shifter that handles four bits per cycle, a setup state latches the
// leading digit and the sign, then characters leave one per cycle while the
// output is ready. The output character sits in its own register, so the
// next item is taken and converted while the last character still waits.

module int_to_decimal_ascii (
  input  logic                                clk,
  input  logic                                rst,
  // input item
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [itda_pkg::VALUE_W-1:0]        s_tdata,   // [31:0] value
  // output item
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [itda_pkg::TDATA_OUT_W-1:0]    m_tdata,   // [6:0] character, [7] zero
  output logic                                m_tlast    // last character of the text
);

  itda_pkg::itda_cmd_t          cmd;
  itda_pkg::itda_status_t       status;
  logic [itda_pkg::CHAR_W-1:0]  character;

  itda_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .status    (status),
    .cmd       (cmd)
  );

  itda_datapath u_datapath (
    .clk       (clk),
    .value     (s_tdata),
    .cmd       (cmd),
    .status    (status),
    .character (character),
    .last      (m_tlast)
  );

  // pad the 7-bit code to a byte
  assign m_tdata = {{(itda_pkg::TDATA_OUT_W - itda_pkg::CHAR_W){1'b0}}, character};

endmodule
